// ----- src/qlrc_pkg.sv -----
// ----------------------------------------------------------------------------
// qlrc_pkg
// Shared types and constants for the quantized query result cache.
// ----------------------------------------------------------------------------
`default_nettype none
package qlrc_pkg;

    localparam int COORD_W = 32;
    localparam int INV_W   = 32;
    localparam int DIST_W  = 32;
    localparam int LABEL_W = 49;
    localparam int KQ_W    = 5;
    localparam int CAP_W   = 7;
    localparam int DIMS_W  = 8;
    localparam int ACT_W   = 2;
    localparam int KEY_W   = 64;
    localparam int TOT_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int CLAMP_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS     = 2'd2;

    localparam logic [CAP_W-1:0]  CAPACITY_RST = 7'd64;
    localparam logic [INV_W-1:0]  INV_STEP_RST = 32'd65536;
    localparam logic [DIMS_W-1:0] DIMS_RST     = 8'd128;

    localparam logic [KEY_W-1:0]   HASH_ADD  = 64'h0000_0000_9e37_79b9;
    localparam int                 HASH_SHL  = 6;
    localparam int                 HASH_SHR  = 2;
    localparam logic [DIST_W-1:0]  PAD_DIST  = 32'h7F7F_FFFF;
    localparam logic [LABEL_W-1:0] PAD_LABEL = {LABEL_W{1'b1}};

    typedef enum logic [ACT_W-1:0] {
        ACT_COORD = 2'd0,
        ACT_FILL  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [KEY_W-1:0]   key;
        logic [KQ_W-1:0]    k;
        logic [DIST_W-1:0]  fill_dist;
        logic [LABEL_W-1:0] label;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_qwr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_HIT_RD,
        ST_HIT_OUT,
        ST_COPY
    } t_state;

endpackage
`default_nettype wire

// ----- src/quantized_query_lru_result_cache_top.sv -----
// ----------------------------------------------------------------------------
// quantized_query_lru_result_cache_top
// LRU cache of neighbor lists keyed by a hash of quantized query vectors.
// ----------------------------------------------------------------------------
// Usage: drive an item with i_start while o_busy is low. Action 0 carries one
// query coordinate; after dims coordinates the hashed key is looked up. A hit
// streams k results (stored pairs, then padding); a miss gives one result of
// kind 1. Action 1 supplies fill pairs, the last of them inserts the entry
// under the latest query key. Action 2 clears entries and counters.
// Results appear for one cycle each on o_result_valid; the receiver cannot
// stall, so results are never held back. Configuration writes go through
// i_cfg_valid/o_cfg_ready (always ready); the user must write only while the
// block is idle, which the block itself does not enforce. A coordinate is
// multiplied, then folded into the hash. Lookup and insert each scan the key
// store once; a hit then emits each result after a stored-pair memory read.
// An insert copies its fill pairs one by one. A two-entry command queue lets
// the front keep taking items while the back works.
// Reset: synchronous, clears all entries, counters and the query in progress.
// ----------------------------------------------------------------------------
`default_nettype none
module quantized_query_lru_result_cache_top
    import qlrc_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int K_MAX   = 16,
    parameter int DIM_MAX = 128
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire logic [ACT_W-1:0]          i_action,
    input  wire logic signed [COORD_W-1:0] i_coord,
    input  wire logic [KQ_W-1:0]           i_want_k,
    input  wire logic [DIST_W-1:0]         i_fill_distance,
    input  wire logic signed [LABEL_W-1:0] i_fill_label,
    input  wire logic                      i_fill_last,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]      i_cfg_data,
    output logic                           o_result_valid,
    output logic                           o_kind,
    output logic [DIST_W-1:0]              o_distance,
    output logic signed [LABEL_W-1:0]      o_label,
    output logic                           o_last,
    output logic [TOT_W-1:0]               o_hit_total,
    output logic [TOT_W-1:0]               o_miss_total
);

    logic [CAP_W-1:0]  r_capacity;
    logic [INV_W-1:0]  r_inv_step;
    logic [DIMS_W-1:0] r_dims;

    t_qwr qwr;
    t_cmd q_cmd;
    logic q_valid, q_full, q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RST;
            r_inv_step <= INV_STEP_RST;
            r_dims     <= DIMS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CAPACITY: r_capacity <= i_cfg_data[CAP_W-1:0];
                CFG_INV_STEP: r_inv_step <= i_cfg_data[INV_W-1:0];
                CFG_DIMS:     r_dims     <= i_cfg_data[DIMS_W-1:0];
                default:      r_dims     <= r_dims;
            endcase
        end
    end

    qlrc_front #(
        .DIM_MAX (DIM_MAX),
        .K_MAX   (K_MAX)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_action        (i_action),
        .i_coord         (i_coord),
        .i_want_k        (i_want_k),
        .i_fill_distance (i_fill_distance),
        .i_fill_label    (i_fill_label),
        .i_fill_last     (i_fill_last),
        .i_inv_step      (r_inv_step),
        .i_dims          (r_dims),
        .i_q_full        (q_full),
        .o_busy          (o_busy),
        .o_qwr           (qwr)
    );

    qlrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_full  (q_full)
    );

    qlrc_back #(
        .ENTRIES (ENTRIES),
        .K_MAX   (K_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_pop        (q_pop),
        .i_capacity   (r_capacity),
        .o_res_valid  (o_result_valid),
        .o_kind       (o_kind),
        .o_distance   (o_distance),
        .o_label      (o_label),
        .o_last       (o_last),
        .o_hit_total  (o_hit_total),
        .o_miss_total (o_miss_total)
    );

endmodule
`default_nettype wire

// ----- src/qlrc_front.sv -----
// ----------------------------------------------------------------------------
// qlrc_front
// Accepts items, quantizes coordinates and folds them into the query hash.
// ----------------------------------------------------------------------------
`default_nettype none
module qlrc_front
    import qlrc_pkg::*;
#(
    parameter int DIM_MAX = 128,
    parameter int K_MAX   = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ACT_W-1:0]          i_action,
    input  wire logic signed [COORD_W-1:0] i_coord,
    input  wire logic [KQ_W-1:0]           i_want_k,
    input  wire logic [DIST_W-1:0]         i_fill_distance,
    input  wire logic signed [LABEL_W-1:0] i_fill_label,
    input  wire logic                      i_fill_last,
    input  wire logic [INV_W-1:0]          i_inv_step,
    input  wire logic [DIMS_W-1:0]         i_dims,
    input  wire logic                      i_q_full,
    output logic                           o_busy,
    output t_qwr                           o_qwr
);

    localparam int CNTW = $clog2(DIM_MAX + 1);

    logic                 r_fold, r_done, r_neg;
    logic [63:0]          r_prod;
    logic [KEY_W-1:0]     r_hbase, r_hash;
    logic [CNTW-1:0]      r_cnt;
    logic [KQ_W-1:0]      r_k;

    logic                 accept;
    logic [CLAMP_W-1:0]   nd;
    logic [KQ_W-1:0]      k_eff;
    logic [COORD_W-1:0]   mag;
    logic [64:0]          rnd;
    logic [32:0]          rq;
    logic [31:0]          q32;
    logic [KEY_W-1:0]     d64, hnew;

    assign o_busy = r_fold || i_q_full;
    assign accept = i_start && !o_busy;

    always_comb begin
        if (i_dims == '0) begin
            nd = CLAMP_W'(1);
        end else if (CLAMP_W'(i_dims) > CLAMP_W'(DIM_MAX)) begin
            nd = CLAMP_W'(DIM_MAX);
        end else begin
            nd = CLAMP_W'(i_dims);
        end
        if (i_want_k == '0) begin
            k_eff = KQ_W'(1);
        end else if (7'(i_want_k) > 7'(K_MAX)) begin
            k_eff = KQ_W'(K_MAX);
        end else begin
            k_eff = i_want_k;
        end
        mag = i_coord[COORD_W-1] ? (~i_coord + 32'd1) : i_coord;
        // round half away from zero on the magnitude, then saturate
        rnd = {1'b0, r_prod} + 65'h0_8000_0000;
        rq  = rnd[64:32];
        if (r_neg) begin
            q32 = -((rq > 33'h0_8000_0000) ? 32'h8000_0000 : rq[31:0]);
        end else begin
            q32 = (rq > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rq[31:0];
        end
        d64  = {{32{q32[31]}}, q32};
        hnew = r_hbase ^ (d64 + HASH_ADD + (r_hbase << HASH_SHL) + (r_hbase >> HASH_SHR));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_hash  <= '0;
            r_k     <= '0;
            r_neg   <= 1'b0;
            r_prod  <= '0;
            r_hbase <= '0;
        end else begin
            if (accept && i_action == ACT_COORD) begin
                r_neg  <= i_coord[COORD_W-1];
                r_prod <= 64'(mag) * 64'(i_inv_step);
                r_fold <= 1'b1;
                if (r_cnt == '0) begin
                    r_k     <= k_eff;
                    r_hbase <= KEY_W'(k_eff);
                end else begin
                    r_hbase <= r_hash;
                end
                if (CLAMP_W'(r_cnt) + CLAMP_W'(1) >= nd) begin
                    r_done <= 1'b1;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    r_cnt  <= r_cnt + CNTW'(1);
                end
            end else if (r_fold) begin
                r_hash <= hnew;
                r_fold <= 1'b0;
            end
        end
    end

    always_comb begin
        o_qwr.cmd.key       = hnew;
        o_qwr.cmd.k         = r_k;
        o_qwr.cmd.fill_dist = i_fill_distance;
        o_qwr.cmd.label     = i_fill_label;
        o_qwr.cmd.last      = i_fill_last;
        o_qwr.cmd.op        = CMD_LOOKUP;
        o_qwr.push          = 1'b0;
        if (r_fold) begin
            o_qwr.push = r_done;
        end else if (accept) begin
            case (i_action)
                ACT_FILL: begin
                    o_qwr.push   = 1'b1;
                    o_qwr.cmd.op = CMD_FILL;
                end
                ACT_CLEAR: begin
                    o_qwr.push   = 1'b1;
                    o_qwr.cmd.op = CMD_CLEAR;
                end
                default: o_qwr.push = 1'b0;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- src/qlrc_queue.sv -----
// ----------------------------------------------------------------------------
// qlrc_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module qlrc_queue
    import qlrc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_qwr i_qwr,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd,
    output logic      o_full
);

    t_cmd       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_qwr.push) begin
            r_slot[r_wp] <= i_qwr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_qwr.push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_qwr.push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

// ----- src/qlrc_back.sv -----
// ----------------------------------------------------------------------------
// qlrc_back
// Cache lookup, LRU bookkeeping, fill insertion and result streaming.
// ----------------------------------------------------------------------------
`default_nettype none
module qlrc_back
    import qlrc_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int K_MAX   = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire t_cmd               i_q_cmd,
    output logic                    o_pop,
    input  wire logic [CAP_W-1:0]   i_capacity,
    output logic                    o_res_valid,
    output logic                    o_kind,
    output logic [DIST_W-1:0]       o_distance,
    output logic [LABEL_W-1:0]      o_label,
    output logic                    o_last,
    output logic [TOT_W-1:0]        o_hit_total,
    output logic [TOT_W-1:0]        o_miss_total
);

    localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW     = $clog2(ENTRIES + 1);
    localparam int KW     = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int FCW    = $clog2(K_MAX + 1);
    localparam int SDEPTH = ENTRIES * (2 ** KW);

    t_state r_state, n_state;

    logic                 r_valid [ENTRIES];
    logic [EW-1:0]        r_rank  [ENTRIES];
    logic [KEY_W-1:0]     r_pending;
    logic [KQ_W-1:0]      r_k, r_i;
    logic [SW-1:0]        r_idx;
    logic                 r_cmp_vld, r_found, r_have_free, r_ins;
    logic [EW-1:0]        r_cmp_idx, r_e, r_free;
    logic [FCW-1:0]       r_len, r_fcnt, r_ci;
    logic [DIST_W-1:0]    r_fbuf_d [K_MAX];
    logic [LABEL_W-1:0]   r_fbuf_l [K_MAX];
    logic [TOT_W-1:0]     r_hits, r_misses;

    logic [KEY_W-1:0]     m_key  [ENTRIES];
    logic [FCW-1:0]       m_len  [ENTRIES];
    logic [DIST_W-1:0]    m_dist [SDEPTH];
    logic [LABEL_W-1:0]   m_lab  [SDEPTH];
    logic [KEY_W-1:0]     r_key_q;
    logic [FCW-1:0]       r_len_q;
    logic [DIST_W-1:0]    r_dist_q;
    logic [LABEL_W-1:0]   r_lab_q;

    logic [CLAMP_W-1:0]   cap_m1;
    logic                 hit_cmp, free_cmp, hit_last, copy_last;
    logic [EW-1:0]        e_rank, w_e;

    assign o_hit_total  = r_hits;
    assign o_miss_total = r_misses;

    always_comb begin
        if (i_capacity == '0) begin
            cap_m1 = '0;
        end else if (CLAMP_W'(i_capacity) > CLAMP_W'(ENTRIES)) begin
            cap_m1 = CLAMP_W'(ENTRIES - 1);
        end else begin
            cap_m1 = CLAMP_W'(i_capacity) - CLAMP_W'(1);
        end
        hit_cmp   = r_cmp_vld && r_valid[r_cmp_idx] && (r_key_q == r_pending);
        // a slot is free if empty, or if it falls to eviction at this capacity
        free_cmp  = r_cmp_vld && (!r_valid[r_cmp_idx] ||
                                  CLAMP_W'(r_rank[r_cmp_idx]) >= cap_m1);
        e_rank    = r_rank[r_e];
        w_e       = r_found ? r_e : r_free;
        hit_last  = (r_i + KQ_W'(1)) == r_k;
        copy_last = (r_ci + FCW'(1)) == r_fcnt;
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    case (i_q_cmd.op)
                        CMD_LOOKUP: n_state = ST_SCAN;
                        CMD_FILL:   n_state = i_q_cmd.last ? ST_SCAN : ST_IDLE;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_idx == SW'(ENTRIES)) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_ins) begin
                    n_state = (r_fcnt != '0) ? ST_COPY : ST_IDLE;
                end else begin
                    n_state = r_found ? ST_HIT_RD : ST_IDLE;
                end
            end
            ST_HIT_RD:  n_state = ST_HIT_OUT;
            ST_HIT_OUT: n_state = hit_last ? ST_IDLE : ST_HIT_RD;
            ST_COPY:    n_state = copy_last ? ST_IDLE : ST_COPY;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // key and length store: one read port for the scan, one write on insert
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && r_idx < SW'(ENTRIES)) begin
            r_key_q <= m_key[r_idx[EW-1:0]];
            r_len_q <= m_len[r_idx[EW-1:0]];
        end
        if (r_state == ST_DECIDE && r_ins) begin
            if (!r_found) begin
                m_key[r_free] <= r_pending;
            end
            m_len[w_e] <= r_fcnt;
        end
    end

    // stored pairs
    always_ff @(posedge i_clk) begin
        if (r_state == ST_HIT_RD) begin
            r_dist_q <= m_dist[{r_e, KW'(r_i)}];
            r_lab_q  <= m_lab[{r_e, KW'(r_i)}];
        end
        if (r_state == ST_COPY) begin
            m_dist[{r_e, r_ci[KW-1:0]}] <= r_fbuf_d[r_ci[KW-1:0]];
            m_lab[{r_e, r_ci[KW-1:0]}]  <= r_fbuf_l[r_ci[KW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_q_valid && i_q_cmd.op == CMD_FILL &&
            r_fcnt < FCW'(K_MAX)) begin
            r_fbuf_d[r_fcnt[KW-1:0]] <= i_q_cmd.fill_dist;
            r_fbuf_l[r_fcnt[KW-1:0]] <= i_q_cmd.label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ENTRIES; j++) begin
                r_valid[j] <= 1'b0;
                r_rank[j]  <= '0;
            end
            r_pending   <= '0;
            r_k         <= '0;
            r_i         <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_cmp_idx   <= '0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
            r_ins       <= 1'b0;
            r_e         <= '0;
            r_free      <= '0;
            r_len       <= '0;
            r_fcnt      <= '0;
            r_ci        <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            o_res_valid <= 1'b0;
            o_kind      <= 1'b0;
            o_distance  <= '0;
            o_label     <= '0;
            o_last      <= 1'b0;
        end else begin
            o_res_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_idx       <= '0;
                    r_cmp_vld   <= 1'b0;
                    r_found     <= 1'b0;
                    r_have_free <= 1'b0;
                    if (i_q_valid) begin
                        case (i_q_cmd.op)
                            CMD_LOOKUP: begin
                                r_pending <= i_q_cmd.key;
                                r_k       <= i_q_cmd.k;
                                r_ins     <= 1'b0;
                            end
                            CMD_FILL: begin
                                if (r_fcnt < FCW'(K_MAX)) begin
                                    r_fcnt <= r_fcnt + FCW'(1);
                                end
                                r_ins <= 1'b1;
                            end
                            CMD_CLEAR: begin
                                for (int j = 0; j < ENTRIES; j++) begin
                                    r_valid[j] <= 1'b0;
                                end
                                r_hits   <= '0;
                                r_misses <= '0;
                            end
                            default: r_ins <= r_ins;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (r_idx < SW'(ENTRIES)) begin
                        r_idx <= r_idx + SW'(1);
                    end
                    r_cmp_vld <= r_idx < SW'(ENTRIES);
                    r_cmp_idx <= r_idx[EW-1:0];
                    if (hit_cmp && !r_found) begin
                        r_found <= 1'b1;
                        r_e     <= r_cmp_idx;
                        r_len   <= r_len_q;
                    end
                    if (free_cmp && !r_have_free) begin
                        r_have_free <= 1'b1;
                        r_free      <= r_cmp_idx;
                    end
                end
                ST_DECIDE: begin
                    r_i  <= '0;
                    r_ci <= '0;
                    if (r_found) begin
                        // move to front: entries more recent than it age by one
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (r_valid[j] && EW'(j) != r_e && r_rank[j] < e_rank) begin
                                r_rank[j] <= r_rank[j] + EW'(1);
                            end
                        end
                        r_rank[r_e] <= '0;
                        if (!r_ins && r_hits != '1) begin
                            r_hits <= r_hits + TOT_W'(1);
                        end
                    end else if (r_ins) begin
                        // drop the oldest beyond capacity, age the rest, insert
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (r_valid[j]) begin
                                if (CLAMP_W'(r_rank[j]) >= cap_m1) begin
                                    r_valid[j] <= 1'b0;
                                end else begin
                                    r_rank[j] <= r_rank[j] + EW'(1);
                                end
                            end
                        end
                        r_valid[r_free] <= 1'b1;
                        r_rank[r_free]  <= '0;
                        r_e             <= r_free;
                    end else begin
                        if (r_misses != '1) begin
                            r_misses <= r_misses + TOT_W'(1);
                        end
                        o_res_valid <= 1'b1;
                        o_kind      <= 1'b1;
                        o_distance  <= '0;
                        o_label     <= '0;
                        o_last      <= 1'b1;
                    end
                end
                ST_HIT_OUT: begin
                    o_res_valid <= 1'b1;
                    o_kind      <= 1'b0;
                    o_last      <= hit_last;
                    if (7'(r_i) < 7'(r_len)) begin
                        o_distance <= r_dist_q;
                        o_label    <= r_lab_q;
                    end else begin
                        o_distance <= PAD_DIST;
                        o_label    <= PAD_LABEL;
                    end
                    r_i <= r_i + KQ_W'(1);
                end
                ST_COPY: begin
                    r_ci <= r_ci + FCW'(1);
                    if (copy_last) begin
                        r_fcnt <= '0;
                    end
                end
                default: r_ins <= r_ins;
            endcase
            if (r_state == ST_DECIDE && r_ins && r_fcnt == '0) begin
                r_fcnt <= '0;
            end
        end
    end

endmodule
`default_nettype wire
